>>> sv/alle_pkg.sv
// Shared constants and types of the array linked list engine.
package alle_pkg;

    // Default sizes of the slot array
    localparam int ALLE_CAPACITY   = 16;
    localparam int ALLE_DATA_WIDTH = 64;

    typedef logic [2:0] t_op;
    typedef logic [1:0] t_status;

    // Operation codes
    localparam t_op OP_ADD_HEAD  = 3'd0;
    localparam t_op OP_ADD_AFTER = 3'd1;
    localparam t_op OP_ADD_TAIL  = 3'd2;
    localparam t_op OP_DEL_HEAD  = 3'd3;
    localparam t_op OP_DEL_AFTER = 3'd4;
    localparam t_op OP_DEL_TAIL  = 3'd5;
    localparam t_op OP_CLEAR     = 3'd6;
    localparam t_op OP_WALK      = 3'd7;

    // Result status codes
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_EMPTY  = 2'd2;
    localparam t_status ST_BADPOS = 2'd3;

endpackage

>>> sv/alle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/array_linked_list_engine_top.sv
// Top level of the array linked list engine: control, list registers and slot memories.
//
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------------------------------
//  request   | start / busy      | i_operation, i_position, i_entry_data
//  result    | o_strobe (1 cyc)  | o_status, o_slot, o_entry_data_res,
//            |                   | o_element_count, o_last
//
// A rejected request (full, empty, bad position) and clear answer at the accept edge, but
// delete after rejects a successor that is not live in S_DA1. Add head runs S_ADD, add
// after S_INS1 and S_INS2, delete head S_DH, delete after S_DA1 and S_DA2. Add tail (S_ADD
// on an empty list) and delete tail walk the links in S_TAIL, one slot per cycle through
// the link memory read port. Walk emits one result per cycle after the read of the head.
// Reset needs no clearing pass: occupancy lives in flip-flops.
// The receiver cannot stall results.
module array_linked_list_engine_top
    import alle_pkg::*;
#(
    parameter int CAPACITY   = ALLE_CAPACITY,
    parameter int DATA_WIDTH = ALLE_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_operation,
    input  logic [$clog2(CAPACITY)-1:0]    i_position,
    input  logic [DATA_WIDTH-1:0]          i_entry_data,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic [$clog2(CAPACITY)-1:0]    o_slot,
    output logic [DATA_WIDTH-1:0]          o_entry_data_res,
    output logic [$clog2(CAPACITY+1)-1:0]  o_element_count,
    output logic                           o_last
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NO_SLOT  = LW'(CAPACITY);
    localparam logic [LW-1:0] LAST_STP = LW'(CAPACITY - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADD  = 4'd1;
    localparam logic [3:0] S_INS1 = 4'd2;
    localparam logic [3:0] S_INS2 = 4'd3;
    localparam logic [3:0] S_TAIL = 4'd4;
    localparam logic [3:0] S_DT   = 4'd5;
    localparam logic [3:0] S_DH   = 4'd6;
    localparam logic [3:0] S_DA1  = 4'd7;
    localparam logic [3:0] S_DA2  = 4'd8;
    localparam logic [3:0] S_WALK = 4'd9;

    // Control registers
    logic [3:0]          r_state,  n_state;
    logic [LW-1:0]       r_head,   n_head;
    logic [LW-1:0]       r_count,  n_count;
    logic [CAPACITY-1:0] r_occ,    n_occ;
    logic [LW-1:0]       r_free,   n_free;
    logic                r_strobe, n_strobe;

    // Working and result payload registers
    t_op                 r_op,     n_op;
    logic [IW-1:0]       r_tgt,    n_tgt;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic [LW-1:0]       r_cur,    n_cur;
    logic [LW-1:0]       r_prev,   n_prev;
    logic [LW-1:0]       r_step,   n_step;
    t_status             r_status, n_status;
    logic [IW-1:0]       r_slot,   n_slot;
    logic [DATA_WIDTH-1:0] r_res,  n_res;
    logic                r_last,   n_last;

    // Memory ports
    logic                  w_lnk_we;
    logic [IW-1:0]         w_lnk_wa;
    logic [LW-1:0]         w_lnk_wd;
    logic                  w_dat_we;
    logic [IW-1:0]         w_rd_addr;
    logic [LW-1:0]         w_lnk_rd;
    logic [DATA_WIDTH-1:0] w_dat_rd;

    logic w_empty;
    logic w_full;
    logic w_pos_live;
    logic w_nx_live;

    // A link names a live entry when it is a slot index and that slot is occupied
    function automatic logic is_live(input logic [LW-1:0] s, input logic [CAPACITY-1:0] occ);
        logic lv;
        lv = 1'b0;
        if (s < NO_SLOT) begin
            lv = occ[s[IW-1:0]];
        end
        return lv;
    endfunction

    // Successor links
    alle_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (w_lnk_we),
        .i_waddr (w_lnk_wa),
        .i_wdata (w_lnk_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_lnk_rd)
    );

    // Entry data words, always written at the free slot
    alle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_dat_ram (
        .i_clk   (i_clk),
        .i_we    (w_dat_we),
        .i_waddr (r_free[IW-1:0]),
        .i_wdata (r_data),
        .i_raddr (w_rd_addr),
        .o_rdata (w_dat_rd)
    );

    assign w_empty    = !is_live(r_head, r_occ);
    assign w_full     = (r_count >= NO_SLOT);
    assign w_pos_live = is_live(LW'(i_position), r_occ);
    assign w_nx_live  = is_live(w_lnk_rd, r_occ);

    // Lowest free slot, registered from the occupancy; it settles before any add uses it
    always_comb begin
        n_free = NO_SLOT;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                n_free = LW'(i);
            end
        end
    end

    // Sequencer
    always_comb begin
        logic [LW-1:0] v_tail;
        logic [LW-1:0] v_prev;
        logic [LW-1:0] v_cnt;
        logic          v_last;

        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_occ    = r_occ;
        n_op     = r_op;
        n_tgt    = r_tgt;
        n_data   = r_data;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_step   = r_step;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_slot   = '0;
        n_res    = '0;
        n_last   = 1'b1;

        w_lnk_we  = 1'b0;
        w_lnk_wa  = r_free[IW-1:0];
        w_lnk_wd  = NO_SLOT;
        w_dat_we  = 1'b0;
        w_rd_addr = r_cur[IW-1:0];

        v_tail = r_cur;
        v_prev = r_prev;
        v_cnt  = (r_count != '0) ? r_count - LW'(1) : r_count;
        v_last = !w_nx_live || (r_step == LAST_STP);

        case (r_state)
            S_IDLE: begin
                if (i_operation == OP_ADD_AFTER || i_operation == OP_DEL_AFTER) begin
                    w_rd_addr = i_position;
                end else begin
                    w_rd_addr = r_head[IW-1:0];
                end
                if (start) begin
                    n_op   = i_operation;
                    n_tgt  = i_position;
                    n_data = i_entry_data;
                    n_cur  = r_head;
                    n_prev = NO_SLOT;
                    n_step = '0;
                    case (i_operation)
                        OP_ADD_HEAD: begin
                            if (w_full) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                        OP_ADD_AFTER: begin
                            if (w_full) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else if (!w_pos_live) begin
                                n_strobe = 1'b1;
                                n_status = ST_BADPOS;
                            end else begin
                                n_state = S_INS1;
                            end
                        end
                        OP_ADD_TAIL: begin
                            if (w_full) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else if (w_empty) begin
                                n_state = S_ADD;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        OP_DEL_HEAD: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_DH;
                            end
                        end
                        OP_DEL_AFTER: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (!w_pos_live) begin
                                n_strobe = 1'b1;
                                n_status = ST_BADPOS;
                            end else begin
                                n_state = S_DA1;
                            end
                        end
                        OP_DEL_TAIL: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        OP_CLEAR: begin
                            n_occ    = '0;
                            n_head   = NO_SLOT;
                            n_count  = '0;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end

            // New head entry; an empty list gets a terminated link
            S_ADD: begin
                w_lnk_we = 1'b1;
                w_lnk_wd = w_empty ? NO_SLOT : r_head;
                w_dat_we = 1'b1;
                n_occ[r_free[IW-1:0]] = 1'b1;
                n_count  = r_count + LW'(1);
                n_head   = r_free;
                n_strobe = 1'b1;
                n_slot   = r_free[IW-1:0];
                n_state  = S_IDLE;
            end

            // New entry takes the predecessor's old link, or ends the list
            S_INS1: begin
                w_lnk_we = 1'b1;
                w_lnk_wd = (r_op == OP_ADD_AFTER) ? w_lnk_rd : NO_SLOT;
                w_dat_we = 1'b1;
                n_state  = S_INS2;
            end

            // Predecessor now points at the new entry
            S_INS2: begin
                w_lnk_we = 1'b1;
                w_lnk_wa = r_tgt;
                w_lnk_wd = r_free;
                n_occ[r_free[IW-1:0]] = 1'b1;
                n_count  = r_count + LW'(1);
                n_strobe = 1'b1;
                n_slot   = r_free[IW-1:0];
                n_state  = S_IDLE;
            end

            // Tail search, one link per cycle, bounded by the capacity
            S_TAIL: begin
                if (!w_nx_live || (r_step == LAST_STP)) begin
                    if (w_nx_live) begin
                        v_tail = w_lnk_rd;
                        v_prev = r_cur;
                    end
                    n_cur     = v_tail;
                    n_prev    = v_prev;
                    n_tgt     = v_tail[IW-1:0];
                    w_rd_addr = v_tail[IW-1:0];
                    n_state   = (r_op == OP_ADD_TAIL) ? S_INS1 : S_DT;
                end else begin
                    n_prev    = r_cur;
                    n_cur     = w_lnk_rd;
                    n_step    = r_step + LW'(1);
                    w_rd_addr = w_lnk_rd[IW-1:0];
                end
            end

            // Unlink the tail; a lone entry empties the list
            S_DT: begin
                if (r_prev < NO_SLOT) begin
                    w_lnk_we = 1'b1;
                    w_lnk_wa = r_prev[IW-1:0];
                    w_lnk_wd = NO_SLOT;
                end else begin
                    n_head = NO_SLOT;
                end
                n_occ[r_cur[IW-1:0]] = 1'b0;
                n_count  = v_cnt;
                n_strobe = 1'b1;
                n_slot   = r_cur[IW-1:0];
                n_res    = w_dat_rd;
                n_state  = S_IDLE;
            end

            // Head moves to its live successor
            S_DH: begin
                n_head = w_nx_live ? w_lnk_rd : NO_SLOT;
                if (v_cnt == '0) begin
                    n_head = NO_SLOT;
                end
                n_occ[r_cur[IW-1:0]] = 1'b0;
                n_count  = v_cnt;
                n_strobe = 1'b1;
                n_slot   = r_cur[IW-1:0];
                n_res    = w_dat_rd;
                n_state  = S_IDLE;
            end

            // Victim is the predecessor's successor; it must be live
            S_DA1: begin
                if (!w_nx_live) begin
                    n_strobe = 1'b1;
                    n_status = ST_BADPOS;
                    n_state  = S_IDLE;
                end else begin
                    n_cur     = w_lnk_rd;
                    w_rd_addr = w_lnk_rd[IW-1:0];
                    n_state   = S_DA2;
                end
            end

            // Bypass the victim
            S_DA2: begin
                w_lnk_we = 1'b1;
                w_lnk_wa = r_tgt;
                w_lnk_wd = w_lnk_rd;
                n_occ[r_cur[IW-1:0]] = 1'b0;
                n_count  = v_cnt;
                n_strobe = 1'b1;
                n_slot   = r_cur[IW-1:0];
                n_res    = w_dat_rd;
                n_state  = S_IDLE;
            end

            // Emit one entry per cycle, reading the next while this one goes out
            S_WALK: begin
                n_strobe = 1'b1;
                n_slot   = r_cur[IW-1:0];
                n_res    = w_dat_rd;
                n_last   = v_last;
                if (v_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_cur     = w_lnk_rd;
                    n_step    = r_step + LW'(1);
                    w_rd_addr = w_lnk_rd[IW-1:0];
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NO_SLOT;
            r_count  <= '0;
            r_occ    <= '0;
            r_free   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_occ    <= n_occ;
            r_free   <= n_free;
            r_strobe <= n_strobe;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_tgt    <= n_tgt;
        r_data   <= n_data;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_step   <= n_step;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_res    <= n_res;
        r_last   <= n_last;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_slot           = r_slot;
    assign o_entry_data_res = r_res;
    assign o_element_count  = r_count;
    assign o_last           = r_last;

endmodule

>>> test/array_linked_list_engine_top_test.sv
// Self-checking testbench of the array linked list engine: directed and random list traffic.
module array_linked_list_engine_top_test
    import alle_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP         = ALLE_CAPACITY;
    localparam int DW          = ALLE_DATA_WIDTH;
    localparam int SLOT_W      = $clog2(CAP);
    localparam int CNT_W       = $clog2(CAP + 1);
    localparam int N_RANDOM    = 250;
    localparam int QUIET_TAIL  = 40;
    localparam int CYCLE_LIMIT = 200000;

    // Traffic mixes of the random part
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } t_mix;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [DW-1:0]      data;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_list_result;

    // Mirror of the slot array plus the queue of results still due
    class list_scoreboard;
        int            head_idx;
        int            fill_count;
        bit            occupied [CAP];
        int            next_link [CAP];
        bit [DW-1:0]   payload [CAP];
        t_list_result  due_results [$];
        int            mismatches;
        int            results_checked;
        int            requests_seen;
        int            status_tally [4];

        function new();
            head_idx   = CAP;
            fill_count = 0;
            foreach (occupied[i]) begin
                occupied[i]  = 1'b0;
                next_link[i] = 0;
                payload[i]   = '0;
            end
        endfunction

        function bit is_live(int s);
            return s >= 0 && s < CAP && occupied[s];
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function int entries();
            return fill_count;
        endfunction

        // Random occupied slot, or any slot when the list is empty
        function int pick_live_slot();
            int live [$];
            foreach (occupied[i]) begin
                if (occupied[i]) live.push_back(i);
            end
            if (live.size() == 0) return $urandom_range(0, CAP - 1);
            return live[$urandom_range(0, live.size() - 1)];
        endfunction

        // Lowest free slot takes the entry
        function int take_slot(bit [DW-1:0] data, int link);
            int s;
            s = 0;
            while (s < CAP && occupied[s]) s++;
            if (s < CAP) begin
                occupied[s]  = 1'b1;
                payload[s]   = data;
                next_link[s] = link;
                fill_count++;
            end
            return s;
        endfunction

        function void free_slot(int s);
            if (s < CAP) begin
                occupied[s] = 1'b0;
                if (fill_count > 0) fill_count--;
            end
        endfunction

        // Follow links to the tail; prev gets the slot ahead of it
        function int find_tail(output int prev);
            int s;
            int nx;
            int n;
            s    = head_idx;
            prev = CAP;
            for (n = 0; n < CAP; n++) begin
                nx = next_link[s];
                if (!is_live(nx)) break;
                prev = s;
                s    = nx;
            end
            return s;
        endfunction

        function void queue_result(t_status st, int s, bit [DW-1:0] d, bit l);
            t_list_result r;
            r.status = st;
            r.slot   = s[SLOT_W-1:0];
            r.data   = d;
            r.count  = fill_count[CNT_W-1:0];
            r.last   = l;
            due_results.push_back(r);
            status_tally[st]++;
        endfunction

        // Apply one accepted request to the mirror and queue its results
        function void note_request(t_op op, logic [SLOT_W-1:0] pos_in, logic [DW-1:0] data);
            int  pos;
            int  s;
            int  p;
            int  t;
            int  nx;
            int  k;
            bit  list_empty;
            pos        = pos_in;
            list_empty = !is_live(head_idx);
            requests_seen++;
            case (op)
                OP_ADD_HEAD, OP_ADD_AFTER, OP_ADD_TAIL: begin
                    // fullness wins over a bad position
                    if (fill_count >= CAP) begin
                        queue_result(ST_FULL, 0, '0, 1'b1);
                    end else if (op == OP_ADD_AFTER && !is_live(pos)) begin
                        queue_result(ST_BADPOS, 0, '0, 1'b1);
                    end else begin
                        if (op == OP_ADD_HEAD) begin
                            s        = take_slot(data, list_empty ? CAP : head_idx);
                            head_idx = s;
                        end else if (op == OP_ADD_AFTER) begin
                            s              = take_slot(data, next_link[pos]);
                            next_link[pos] = s;
                        end else if (list_empty) begin
                            s        = take_slot(data, CAP);
                            head_idx = s;
                        end else begin
                            t            = find_tail(p);
                            s            = take_slot(data, CAP);
                            next_link[t] = s;
                        end
                        queue_result(ST_OK, s, '0, 1'b1);
                    end
                end
                OP_DEL_HEAD, OP_DEL_TAIL: begin
                    if (list_empty) begin
                        queue_result(ST_EMPTY, 0, '0, 1'b1);
                    end else begin
                        s = head_idx;
                        p = CAP;
                        if (op == OP_DEL_TAIL) s = find_tail(p);
                        if (p < CAP) begin
                            next_link[p] = CAP;
                            free_slot(s);
                        end else begin
                            // head removal, also the tail of a one-entry list
                            s        = head_idx;
                            head_idx = is_live(next_link[s]) ? next_link[s] : CAP;
                            free_slot(s);
                            if (fill_count == 0) head_idx = CAP;
                        end
                        queue_result(ST_OK, s, payload[s], 1'b1);
                    end
                end
                OP_DEL_AFTER: begin
                    if (list_empty) begin
                        queue_result(ST_EMPTY, 0, '0, 1'b1);
                    end else if (!is_live(pos) || !is_live(next_link[pos])) begin
                        queue_result(ST_BADPOS, 0, '0, 1'b1);
                    end else begin
                        s              = next_link[pos];
                        next_link[pos] = next_link[s];
                        free_slot(s);
                        queue_result(ST_OK, s, payload[s], 1'b1);
                    end
                end
                OP_CLEAR: begin
                    foreach (occupied[i]) occupied[i] = 1'b0;
                    head_idx   = CAP;
                    fill_count = 0;
                    queue_result(ST_OK, 0, '0, 1'b1);
                end
                default: begin
                    // walk: one result per entry in list order
                    if (list_empty) begin
                        queue_result(ST_EMPTY, 0, '0, 1'b1);
                    end else begin
                        k = 0;
                        s = head_idx;
                        while (k < CAP && is_live(s)) begin
                            nx = next_link[s];
                            queue_result(ST_OK, s, payload[s], (k + 1 >= CAP) || !is_live(nx));
                            k++;
                            s = nx;
                        end
                    end
                end
            endcase
        endfunction

        // Compare one strobed result against the oldest one due
        function void check_result(t_status st, logic [SLOT_W-1:0] sl, logic [DW-1:0] d,
                                   logic [CNT_W-1:0] c, logic l);
            t_list_result want;
            results_checked++;
            if (due_results.size() == 0) begin
                $error("unexpected result: status %0d slot %0d count %0d", st, sl, c);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                mismatches++;
            end
            if (sl !== want.slot) begin
                $error("slot: expected %0d, actual %0d", want.slot, sl);
                mismatches++;
            end
            if (d !== want.data) begin
                $error("entry_data_res: expected %h, actual %h", want.data, d);
                mismatches++;
            end
            if (c !== want.count) begin
                $error("element_count: expected %0d, actual %0d", want.count, c);
                mismatches++;
            end
            if (l !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, l);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [2:0]           i_operation  = OP_WALK;
    logic [SLOT_W-1:0]    i_position   = '0;
    logic [DW-1:0]        i_entry_data = '0;
    logic                 o_strobe;
    logic [1:0]           o_status;
    logic [SLOT_W-1:0]    o_slot;
    logic [DW-1:0]        o_entry_data_res;
    logic [CNT_W-1:0]     o_element_count;
    logic                 o_last;

    list_scoreboard board = new();
    int cycle_count = 0;

    array_linked_list_engine_top #(
        .CAPACITY   (CAP),
        .DATA_WIDTH (DW)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_entry_data     (i_entry_data),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_entry_data_res (o_entry_data_res),
        .o_element_count  (o_element_count),
        .o_last           (o_last)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Requests are noted before results are checked, so a same-cycle answer works too
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0) begin
                board.note_request(i_operation, i_position, i_entry_data);
            end
            if (o_strobe === 1'b1) begin
                board.check_result(o_status, o_slot, o_entry_data_res, o_element_count,
                                   o_last);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[array_linked_list_engine_top] ERROR");
        $finish;
    end

    // Present a request and hold it until the accept edge
    task automatic send_request(t_op op, int pos, logic [DW-1:0] data);
        start        <= 1'b1;
        i_operation  <= op;
        i_position   <= pos[SLOT_W-1:0];
        i_entry_data <= data;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // start may already be low right after a gap
    task automatic wait_drained();
        if (start !== 1'b0) start <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic t_op choose_op(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (r < 30) return OP_ADD_HEAD;
                if (r < 55) return OP_ADD_AFTER;
                if (r < 80) return OP_ADD_TAIL;
                if (r < 85) return OP_DEL_HEAD;
                if (r < 90) return OP_DEL_AFTER;
                if (r < 94) return OP_DEL_TAIL;
                return OP_WALK;
            end
            MIX_SHRINK: begin
                if (r < 10) return OP_ADD_HEAD;
                if (r < 15) return OP_ADD_AFTER;
                if (r < 20) return OP_ADD_TAIL;
                if (r < 40) return OP_DEL_HEAD;
                if (r < 65) return OP_DEL_AFTER;
                if (r < 90) return OP_DEL_TAIL;
                if (r < 96) return OP_WALK;
                return OP_CLEAR;
            end
            default: return t_op'($urandom_range(0, 7));
        endcase
    endfunction

    // Mostly random words, with the all-zero and all-one extremes now and then
    function automatic logic [DW-1:0] choose_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return {$urandom, $urandom};
    endfunction

    // Stimulus
    initial begin
        int    sent;
        int    directed;
        int    episode;
        int    run_len;
        int    pos;
        bit    gaps_on;
        t_mix  mix;
        t_op   op;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list errors, insert variants, bad positions, tail cases
        send_request(OP_WALK, 0, '0);
        send_request(OP_DEL_HEAD, 0, '0);
        send_request(OP_DEL_TAIL, 0, '0);
        send_request(OP_DEL_AFTER, 0, '0);
        send_request(OP_ADD_AFTER, 5, '1);
        send_request(OP_ADD_TAIL, 0, '1);
        send_request(OP_ADD_HEAD, 15, '0);
        send_request(OP_ADD_AFTER, 0, 64'hA5A5_5A5A_0F0F_F0F0);
        send_request(OP_ADD_AFTER, 15, '1);
        send_request(OP_DEL_AFTER, 2, '0);
        send_request(OP_WALK, 0, '0);
        send_request(OP_DEL_AFTER, 1, '0);
        send_request(OP_DEL_TAIL, 0, '0);
        send_request(OP_DEL_TAIL, 0, '0);
        send_request(OP_ADD_HEAD, 0, 64'h8000_0000_0000_0001);
        send_request(OP_ADD_TAIL, 0, 64'h7FFF_FFFF_FFFF_FFFE);
        send_request(OP_CLEAR, 0, '0);
        send_request(OP_WALK, 0, '0);
        // stale links after clear must not leak into the new list
        send_request(OP_ADD_TAIL, 0, 64'h1234_5678_9ABC_DEF0);
        send_request(OP_ADD_TAIL, 0, 64'h0FED_CBA9_8765_4321);
        send_request(OP_WALK, 0, '0);
        send_request(OP_DEL_HEAD, 0, '0);
        directed = 22;

        // Random episodes of biased traffic, with and without gaps
        sent    = 0;
        episode = 0;
        while (sent < N_RANDOM) begin
            mix     = (episode == 0) ? MIX_GROW : t_mix'($urandom_range(0, 2));
            run_len = $urandom_range(15, 40);
            gaps_on = $urandom_range(0, 3) != 0;
            for (int i = 0; i < run_len && sent < N_RANDOM; i++) begin
                op = choose_op(mix);
                if ((op == OP_ADD_AFTER || op == OP_DEL_AFTER) && board.entries() > 0 &&
                    $urandom_range(0, 9) < 8) begin
                    pos = board.pick_live_slot();
                end else begin
                    pos = $urandom_range(0, CAP - 1);
                end
                send_request(op, pos, choose_data());
                sent++;
                if (gaps_on && sent < N_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                    idle_gap($urandom_range(1, 13));
                end
            end
            // hold off until the engine has answered everything
            if (episode == 2 ||
                (sent < N_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0)) begin
                wait_drained();
            end
            episode++;
        end

        wait_drained();
        repeat (CAP + 8) @(posedge i_clk);

        $display("Ran %0d requests (%0d directed, %0d random episodes), %0d results checked",
                 board.requests_seen, directed, episode, board.results_checked);
        $display("Result mix: ok %0d, full %0d, empty %0d, bad position %0d",
                 board.status_tally[ST_OK], board.status_tally[ST_FULL],
                 board.status_tally[ST_EMPTY], board.status_tally[ST_BADPOS]);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("[array_linked_list_engine_top] OK");
        end else begin
            $display("[array_linked_list_engine_top] ERROR");
        end
        $finish;
    end

endmodule
